FILE: hdl/pds_pkg.sv
// Shared widths, constants, register indexes and sequencer states of the PLL divider search.
package pds_pkg;

   // Field and register widths
   localparam int TARGET_W     = 16;
   localparam int T_W          = 15;
   localparam int REF_FREQ_W   = 16;
   localparam int REF_DIV_W    = 8;
   localparam int NUM_PD_W     = 3;
   localparam int POST_DIV_W   = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int FB_DIV_W     = 8;
   localparam int POST_INDEX_W = 2;
   localparam int OUT_FREQ_W   = 25;
   localparam int NUM_PD_REGS  = 4;

   // Datapath widths
   localparam int MUL_A_W      = 23;
   localparam int MUL_B_W      = 8;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int DIVIDEND_W   = 32;
   localparam int DIVISOR_W    = 17;
   localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);
   localparam int VCO_W        = 23;

   // Limits
   localparam logic [T_W-1:0]      T_MIN   = 15'd1475;
   localparam logic [T_W-1:0]      T_MAX   = 15'd23500;
   localparam logic [VCO_W-1:0]    VCO_MIN = 23'd10000;
   localparam logic [VCO_W-1:0]    VCO_MAX = 23'd20000;

   // Reset values of the configuration registers
   localparam logic [REF_FREQ_W-1:0] REF_FREQ_RST = 16'd1432;
   localparam logic [REF_DIV_W-1:0]  REF_DIV_RST  = 8'd1;
   localparam logic [NUM_PD_W-1:0]   NUM_PD_RST   = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_FREQ      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_DIV       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_POST_DIVS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_DIV_0    = 3'd3;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TM,
      ST_TMP,
      ST_VCO,
      ST_DIVN_GO,
      ST_DIVN_WAIT,
      ST_RN,
      ST_MP,
      ST_DIVF_GO,
      ST_DIVF_WAIT,
      ST_CMP,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/pds_mul.sv
// Shared registered multiplier of the divider search datapath.
module pds_mul (
   input  logic                        clock,
   input  logic [pds_pkg::MUL_A_W-1:0] a,
   input  logic [pds_pkg::MUL_B_W-1:0] b,
   output logic [pds_pkg::MUL_P_W-1:0] prod_ff
);
   import pds_pkg::*;

   logic [MUL_P_W-1:0] prod_in;

   // One product per cycle, registered before use.
   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: hdl/pds_divider.sv
// Shared restoring divider that produces one quotient bit per cycle.
module pds_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pds_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [pds_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           done_ff,
   output logic [pds_pkg::DIVIDEND_W-1:0] quo_ff
);
   import pds_pkg::*;

   logic                  busy_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      qbit  = (trial >= {1'b0, dvs_ff});
   end

   // Control: run for one step per dividend bit, then pulse done.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIVIDEND_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend shifts out as quotient bits shift in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], qbit};
      end
   end

endmodule

FILE: hdl/pll_divider_search.sv
// Each tried post divider entry runs the divider twice, once for N and once for the output
// frequency; an entry that fails the N or VCO check is skipped after the first run.
// A zero reference or a zero entry count gives the result in the cycle after acceptance.
// The 32-step serial divider sets the search time.
// Throughput: one request at a time; busy stays high through the result strobe cycle.
// Reset (synchronous, active high) idles the sequencer and loads register defaults; no stall.
module pll_divider_search #(
   parameter int MAX_POST_DIVS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pds_pkg::TARGET_W-1:0]     req_target_freq,
   input  logic                             csr_we,
   input  logic [pds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pds_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [pds_pkg::FB_DIV_W-1:0]     rsp_feedback_div,
   output logic [pds_pkg::POST_INDEX_W-1:0] rsp_post_index,
   output logic [pds_pkg::OUT_FREQ_W-1:0]   rsp_out_freq
);
   import pds_pkg::*;

   localparam int IDX_W = (MAX_POST_DIVS > 1) ? $clog2(MAX_POST_DIVS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POST_DIVS - 1);

   state_type                state_ff, state_in;

   logic [REF_FREQ_W-1:0]    ref_freq_ff;
   logic [REF_DIV_W-1:0]     ref_div_ff;
   logic [NUM_PD_W-1:0]      num_pd_ff;
   logic [POST_DIV_W-1:0]    post_div [MAX_POST_DIVS];

   logic [T_W-1:0]           t_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [DIVIDEND_W-1:0]    num_ff;
   logic [VCO_W-1:0]         vco_ff;
   logic [FB_DIV_W-1:0]      n_ff;
   logic [OUT_FREQ_W-1:0]    f_ff;

   logic                     found_ff;
   logic [OUT_FREQ_W-1:0]    best_err_ff;
   logic [FB_DIV_W-1:0]      best_n_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [OUT_FREQ_W-1:0]    best_f_ff;

   logic [T_W-1:0]           t_clamp;
   logic [IDX_W-1:0]         first_idx;
   logic [POST_DIV_W-1:0]    p_cur;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [MUL_P_W-1:0]       prod_ff;
   logic                     div_start;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_quo;
   logic                     n_ok;
   logic                     vco_ok;
   logic [OUT_FREQ_W-1:0]    err;
   logic                     better;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_freq_ff <= REF_FREQ_RST;
         ref_div_ff  <= REF_DIV_RST;
         num_pd_ff   <= NUM_PD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REF_FREQ:      ref_freq_ff <= csr_wdata;
            CSR_REF_DIV:       ref_div_ff  <= csr_wdata[REF_DIV_W-1:0];
            CSR_NUM_POST_DIVS: num_pd_ff   <= csr_wdata[NUM_PD_W-1:0];
            default:           ;
         endcase
      end
   end

   // Post divider table: the first entries are writable, the rest are fixed powers of two.
   for (genvar k = 0; k < MAX_POST_DIVS; k++) begin : g_pd
      if (k < NUM_PD_REGS) begin : g_reg
         logic [POST_DIV_W-1:0] pd_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               pd_ff <= POST_DIV_W'(1) << k;
            end else if (csr_we && (csr_index == CSR_POST_DIV_0 + CSR_INDEX_W'(k))) begin
               pd_ff <= csr_wdata[POST_DIV_W-1:0];
            end
         end
         assign post_div[k] = pd_ff;
      end else begin : g_fixed
         assign post_div[k] = POST_DIV_W'(1) << (k % 8);
      end
   end

   // Request clamping and the first table index to try.
   always_comb begin
      if (req_target_freq < TARGET_W'(T_MIN)) begin
         t_clamp = T_MIN;
      end else if (req_target_freq > TARGET_W'(T_MAX)) begin
         t_clamp = T_MAX;
      end else begin
         t_clamp = req_target_freq[T_W-1:0];
      end
      if (int'(num_pd_ff) > MAX_POST_DIVS) begin
         first_idx = LAST_IDX;
      end else begin
         first_idx = IDX_W'(num_pd_ff - 3'd1);
      end
   end

   assign p_cur = post_div[idx_ff];

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = MUL_A_W'(t_ff);
      mul_b = ref_div_ff;
      case (state_ff)
         ST_TMP: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = p_cur;
         end
         ST_VCO:  mul_b = p_cur;
         ST_RN: begin
            mul_a = MUL_A_W'({ref_freq_ff, 1'b0});
            mul_b = n_ff;
         end
         ST_MP: begin
            mul_a = MUL_A_W'(ref_div_ff);
            mul_b = p_cur;
         end
         default: ;
      endcase
   end

   pds_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   // The divider first yields N from 2R, then the output frequency from M*P.
   assign div_start   = (state_ff == ST_DIVN_GO) || (state_ff == ST_DIVF_GO);
   assign div_divisor = (state_ff == ST_DIVN_GO) ? {ref_freq_ff, 1'b0}
                                                 : DIVISOR_W'(prod_ff[15:0]);

   pds_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (div_divisor),
      .done_ff  (div_done),
      .quo_ff   (div_quo)
   );

   // Range checks on N and the VCO product, and the error of the candidate.
   always_comb begin
      n_ok   = (div_quo[DIVIDEND_W-1:FB_DIV_W] == '0) && div_quo[FB_DIV_W-1];
      vco_ok = (vco_ff >= VCO_MIN) && (vco_ff <= VCO_MAX);
      if (f_ff > OUT_FREQ_W'(t_ff)) begin
         err = f_ff - OUT_FREQ_W'(t_ff);
      end else begin
         err = OUT_FREQ_W'(t_ff) - f_ff;
      end
      better = !found_ff || (err < best_err_ff);
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((ref_freq_ff == '0) || (num_pd_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_TM;
               end
            end
         end
         ST_TM:        state_in = ST_TMP;
         ST_TMP:       state_in = ST_VCO;
         ST_VCO:       state_in = ST_DIVN_GO;
         ST_DIVN_GO:   state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: begin
            if (div_done) begin
               state_in = (n_ok && vco_ok) ? ST_RN : ST_NEXT;
            end
         end
         ST_RN:        state_in = ST_MP;
         ST_MP:        state_in = ST_DIVF_GO;
         ST_DIVF_GO:   state_in = ST_DIVF_WAIT;
         ST_DIVF_WAIT: begin
            if (div_done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP:       state_in = ST_NEXT;
         ST_NEXT:      state_in = (idx_ff == '0) ? ST_DONE : ST_TM;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Per-request datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            t_ff   <= t_clamp;
            idx_ff <= first_idx;
         end
         ST_VCO:       num_ff <= DIVIDEND_W'(prod_ff) + DIVIDEND_W'(ref_freq_ff) - 1'b1;
         ST_DIVN_GO:   vco_ff <= prod_ff[VCO_W-1:0];
         ST_DIVN_WAIT: n_ff   <= div_quo[FB_DIV_W-1:0];
         ST_MP:        num_ff <= DIVIDEND_W'(prod_ff);
         ST_DIVF_WAIT: f_ff   <= div_quo[OUT_FREQ_W-1:0];
         ST_NEXT:      idx_ff <= idx_ff - 1'b1;
         default:      ;
      endcase
   end

   // Best candidate so far; a later (lower) index wins only with a strictly smaller error.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if ((state_ff == ST_IDLE) && start) begin
         found_ff <= 1'b0;
      end else if ((state_ff == ST_CMP) && better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && start) begin
         best_err_ff <= '0;
         best_n_ff   <= '0;
         best_idx_ff <= '0;
         best_f_ff   <= '0;
      end else if ((state_ff == ST_CMP) && better) begin
         best_err_ff <= err;
         best_n_ff   <= n_ff;
         best_idx_ff <= idx_ff;
         best_f_ff   <= f_ff;
      end
   end

   // Handshake and result ports
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_found        = found_ff;
   assign rsp_feedback_div = best_n_ff;
   assign rsp_post_index   = POST_INDEX_W'(best_idx_ff);
   assign rsp_out_freq     = best_f_ff;

endmodule

FILE: hdl/pds_checker.sv
// Port-level checker for the PLL divider search, bound to the top level.
module pds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_found,
   input logic [pds_pkg::FB_DIV_W-1:0]     rsp_feedback_div,
   input logic [pds_pkg::POST_INDEX_W-1:0] rsp_post_index,
   input logic [pds_pkg::OUT_FREQ_W-1:0]   rsp_out_freq
);
   import pds_pkg::*;

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A result belongs to a request in flight.
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe without a request in flight");

   // Each request gives a single one-cycle result, after which the block is free.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // With nothing found, every result field is zero.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         ((rsp_feedback_div == '0) && (rsp_post_index == '0) && (rsp_out_freq == '0)))
      else $error("fields not zero on a result with nothing found");

   // A found feedback divider lies in its upper half range.
   a_found_n_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> rsp_feedback_div[FB_DIV_W-1])
      else $error("feedback divider out of range");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_found        (rsp_found),
   .rsp_feedback_div (rsp_feedback_div),
   .rsp_post_index   (rsp_post_index),
   .rsp_out_freq     (rsp_out_freq)
);

FILE: tb/pll_divider_search_tb.sv
// Self-checking testbench for the PLL feedback and post-divider search block.
`timescale 1ns / 100ps

module pll_divider_search_tb;
   import pds_pkg::*;

   // Feedback divider window and run limits
   localparam logic [63:0] FB_DIV_MIN  = 64'd128;
   localparam logic [63:0] FB_DIV_MAX  = 64'd255;
   localparam int          CYCLE_LIMIT = 5_000_000;
   localparam int          PHASES      = 26;
   localparam int          PHASE_ITEMS = 50;
   localparam int          DRAIN_WAIT  = 400;

   // Named indexes of the remaining post divider registers
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_DIV_1 = CSR_POST_DIV_0 + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_DIV_2 = CSR_POST_DIV_0 + 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_DIV_3 = CSR_POST_DIV_0 + 3'd3;

   typedef struct packed {
      logic                    found;
      logic [FB_DIV_W-1:0]     feedback_div;
      logic [POST_INDEX_W-1:0] post_index;
      logic [OUT_FREQ_W-1:0]   out_freq;
   } pll_setting_type;

   typedef struct {
      logic [TARGET_W-1:0] target;
      pll_setting_type     setting;
   } pending_setting_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      bit                     not_found;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [TARGET_W-1:0]     req_target_freq = '0;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [FB_DIV_W-1:0]     rsp_feedback_div;
   logic [POST_INDEX_W-1:0] rsp_post_index;
   logic [OUT_FREQ_W-1:0]   rsp_out_freq;

   // Local copy of the divider setup, updated as each write lands
   logic [REF_FREQ_W-1:0] cfg_ref_freq = REF_FREQ_RST;
   logic [REF_DIV_W-1:0]  cfg_ref_div = REF_DIV_RST;
   logic [NUM_PD_W-1:0]   cfg_num_post_divs = NUM_PD_RST;
   logic [POST_DIV_W-1:0] cfg_post_div [NUM_PD_REGS] = '{8'd1, 8'd2, 8'd4, 8'd8};

   pending_setting_type pending_settings[$];
   int                  fail_count = 0;
   int                  cycle_count = 0;
   int                  gap_pct = 14;

   pll_divider_search dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_target_freq  (req_target_freq),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_feedback_div (rsp_feedback_div),
      .rsp_post_index   (rsp_post_index),
      .rsp_out_freq     (rsp_out_freq)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Walk the post divider table from the top entry down and keep the closest fit.
   function automatic pll_setting_type predict_pll_setting(input logic [TARGET_W-1:0] target);
      logic [63:0]     t, r, m, p, n, vco, f, err, best_err;
      int              count;
      bit              hit;
      pll_setting_type best;
      t = target;
      if (t < T_MIN) t = T_MIN;
      if (t > T_MAX) t = T_MAX;
      r = cfg_ref_freq;
      m = cfg_ref_div;
      count = (cfg_num_post_divs > NUM_PD_REGS) ? NUM_PD_REGS : cfg_num_post_divs;
      best = '0;
      best_err = '0;
      hit = 1'b0;
      if (r != 0) begin
         for (int k = count - 1; k >= 0; k--) begin
            p = cfg_post_div[k];
            n = (t * m * p + r - 1) / (2 * r);
            if (n < FB_DIV_MIN || n > FB_DIV_MAX) continue;
            vco = t * p;
            if (vco < VCO_MIN || vco > VCO_MAX) continue;
            // A feedback divider of 128 or more means m and p are both nonzero.
            f = (2 * r * n) / (m * p);
            err = (f > t) ? f - t : t - f;
            // Strictly smaller error only, so the higher index wins a tie.
            if (!hit || err < best_err) begin
               hit = 1'b1;
               best_err = err;
               best.found = 1'b1;
               best.feedback_div = FB_DIV_W'(n);
               best.post_index = POST_INDEX_W'(k);
               best.out_freq = OUT_FREQ_W'(f);
            end
         end
      end
      return best;
   endfunction

   function automatic stim_row_type mk_req(input logic [TARGET_W-1:0] target,
                                           input bit not_found);
      stim_row_type row;
      row.kind = ROW_REQ;
      row.index = '0;
      row.value = target;
      row.not_found = not_found;
      return row;
   endfunction

   function automatic stim_row_type mk_csr(input logic [CSR_INDEX_W-1:0] index,
                                           input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.index = index;
      row.value = data;
      row.not_found = 1'b0;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] ERROR %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Put one register write on the port; the write enable stays up for a following write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_REF_FREQ:      cfg_ref_freq = data;
         CSR_REF_DIV:       cfg_ref_div = data[REF_DIV_W-1:0];
         CSR_NUM_POST_DIVS: cfg_num_post_divs = data[NUM_PD_W-1:0];
         CSR_POST_DIV_0:    cfg_post_div[0] = data[POST_DIV_W-1:0];
         CSR_POST_DIV_1:    cfg_post_div[1] = data[POST_DIV_W-1:0];
         CSR_POST_DIV_2:    cfg_post_div[2] = data[POST_DIV_W-1:0];
         CSR_POST_DIV_3:    cfg_post_div[3] = data[POST_DIV_W-1:0];
         default: ;
      endcase
   endtask

   // Issue one request; start stays high afterwards so back-to-back requests need no toggle.
   // Now and then the sender holds off for a random span, which lands anywhere in the search.
   task automatic issue_request(input logic [TARGET_W-1:0] target, input bit not_found);
      pending_setting_type item;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(350, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_target_freq <= target;
      @(posedge clock);
      while (busy) @(posedge clock);
      item.target = target;
      item.setting = not_found ? pll_setting_type'('0) : predict_pll_setting(target);
      pending_settings.push_back(item);
   endtask

   // Drop start and wait until every request has come back and the block is idle.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_settings.size() != 0 || busy) @(posedge clock);
   endtask

   // Compare each result strobe with the oldest pending request.
   always @(posedge clock) begin : check_results
      pending_setting_type want;
      string               tag;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_settings.size() == 0) begin
            report_mismatch("result with no request pending, out_freq", rsp_out_freq, 0);
         end else begin
            want = pending_settings.pop_front();
            tag = $sformatf("target %0d", want.target);
            if (rsp_found !== want.setting.found)
               report_mismatch({tag, " found"}, rsp_found, want.setting.found);
            if (rsp_feedback_div !== want.setting.feedback_div)
               report_mismatch({tag, " feedback_div"}, rsp_feedback_div,
                               want.setting.feedback_div);
            if (rsp_post_index !== want.setting.post_index)
               report_mismatch({tag, " post_index"}, rsp_post_index, want.setting.post_index);
            if (rsp_out_freq !== want.setting.out_freq)
               report_mismatch({tag, " out_freq"}, rsp_out_freq, want.setting.out_freq);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pll_divider_search verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type rows[$];
      bit           writing;
      int           prof, sel, r, m, num, pd_pick;
      int           pd[NUM_PD_REGS];
      int           pd_choices[8];
      logic [TARGET_W-1:0] target;

      pd_choices = '{1, 2, 3, 4, 5, 6, 8, 12};

      // With the reset setup the reference divider is 1, so the feedback divider stays
      // far below 128 and nothing fits.
      rows.push_back(mk_req(16'd0, 1'b1));
      rows.push_back(mk_req(16'd65535, 1'b1));
      rows.push_back(mk_req(16'd1475, 1'b1));
      rows.push_back(mk_req(16'd23500, 1'b1));
      // A realistic reference divider; targets on clamps and VCO window edges.
      rows.push_back(mk_csr(CSR_REF_DIV, 16'd36));
      rows.push_back(mk_req(16'd15000, 1'b0));
      rows.push_back(mk_req(16'd7500, 1'b0));
      rows.push_back(mk_req(16'd1475, 1'b0));
      rows.push_back(mk_req(16'd1474, 1'b0));
      rows.push_back(mk_req(16'd23501, 1'b0));
      rows.push_back(mk_req(16'd10000, 1'b0));
      rows.push_back(mk_req(16'd20000, 1'b0));
      rows.push_back(mk_req(16'd5000, 1'b0));
      // Two equal table entries: the tie goes to the higher index.
      rows.push_back(mk_csr(CSR_POST_DIV_0, 16'd2));
      rows.push_back(mk_req(16'd7500, 1'b0));
      rows.push_back(mk_req(16'd6000, 1'b0));
      // Entry count above the table size saturates.
      rows.push_back(mk_csr(CSR_NUM_POST_DIVS, 16'd7));
      rows.push_back(mk_req(16'd2000, 1'b0));
      rows.push_back(mk_req(16'd12000, 1'b0));
      // An entry count of zero searches nothing.
      rows.push_back(mk_csr(CSR_NUM_POST_DIVS, 16'd0));
      rows.push_back(mk_req(16'd15000, 1'b1));
      // Zero reference frequency; the upper data bits of the count are ignored.
      rows.push_back(mk_csr(CSR_NUM_POST_DIVS, 16'hFFFC));
      rows.push_back(mk_csr(CSR_REF_FREQ, 16'd0));
      rows.push_back(mk_req(16'd15000, 1'b1));
      // Zero reference divider keeps the feedback divider at zero.
      rows.push_back(mk_csr(CSR_REF_FREQ, 16'd1432));
      rows.push_back(mk_csr(CSR_REF_DIV, 16'd0));
      rows.push_back(mk_req(16'd15000, 1'b1));
      // Zero and maximum post dividers; upper data bits of the reference divider are ignored.
      rows.push_back(mk_csr(CSR_REF_DIV, 16'hFF24));
      rows.push_back(mk_csr(CSR_POST_DIV_3, 16'd0));
      rows.push_back(mk_csr(CSR_POST_DIV_2, 16'd255));
      rows.push_back(mk_csr(CSR_POST_DIV_1, 16'd1));
      rows.push_back(mk_req(16'd1475, 1'b0));
      rows.push_back(mk_req(16'd15000, 1'b0));
      // Extreme reference values.
      rows.push_back(mk_csr(CSR_REF_FREQ, 16'd65535));
      rows.push_back(mk_csr(CSR_REF_DIV, 16'd255));
      rows.push_back(mk_req(16'd10000, 1'b0));
      rows.push_back(mk_csr(CSR_REF_FREQ, 16'd1));
      rows.push_back(mk_req(16'd12345, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      writing = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            if (!writing) wait_idle();
            write_csr(rows[i].index, rows[i].value);
            writing = 1'b1;
         end else begin
            if (writing) csr_we <= 1'b0;
            writing = 1'b0;
            issue_request(rows[i].value, rows[i].not_found);
         end
      end

      // Random phases, each with a fresh divider setup.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         prof = $urandom_range(99);
         if (prof < 70) begin
            // Plausible setup: the reference divider puts N near the middle of its window.
            r = $urandom_range(4000, 500);
            m = (r * 38 + 750) / 1500 + $urandom_range(6) - 3;
            if (m < 1) m = 1;
            if (m > 255) m = 255;
            num = $urandom_range(1) ? 4 : $urandom_range(4, 1);
            foreach (pd[k]) pd[k] = pd_choices[$urandom_range(7)];
         end else if (prof < 85) begin
            // Extremes of every register.
            case ($urandom_range(3))
               0: r = 0;
               1: r = 1;
               2: r = 65535;
               default: r = $urandom_range(65535, 1);
            endcase
            case ($urandom_range(3))
               0: m = 0;
               1: m = 1;
               2: m = 255;
               default: m = 36;
            endcase
            foreach (pd[k]) begin
               pd_pick = $urandom_range(3);
               pd[k] = (pd_pick == 0) ? 0 : (pd_pick == 1) ? 1 :
                       (pd_pick == 2) ? 255 : $urandom_range(16, 1);
            end
            num = $urandom_range(7);
         end else begin
            r = $urandom_range(65535);
            m = $urandom_range(255);
            num = $urandom_range(7);
            foreach (pd[k]) pd[k] = $urandom_range(255);
         end
         write_csr(CSR_REF_FREQ, CSR_DATA_W'(r));
         write_csr(CSR_REF_DIV, {8'($urandom), 8'(m)});
         write_csr(CSR_NUM_POST_DIVS, {13'($urandom), 3'(num)});
         write_csr(CSR_POST_DIV_0, {8'($urandom), 8'(pd[0])});
         write_csr(CSR_POST_DIV_1, {8'($urandom), 8'(pd[1])});
         write_csr(CSR_POST_DIV_2, {8'($urandom), 8'(pd[2])});
         write_csr(CSR_POST_DIV_3, {8'($urandom), 8'(pd[3])});
         csr_we <= 1'b0;

         // A stretch of phases runs with no sender gaps at all.
         gap_pct = (phase >= 8 && phase < 14) ? 0 : 14;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(99);
            if (sel < 10) begin
               target = TARGET_W'($urandom);
            end else if (sel < 20) begin
               target = $urandom_range(1) ? TARGET_W'($urandom_range(T_MIN)) :
                                            TARGET_W'($urandom_range(65535, T_MAX));
            end else if (sel < 35) begin
               // Just around a VCO window edge for one of the table entries.
               pd_pick = cfg_post_div[$urandom_range(NUM_PD_REGS - 1)];
               if (pd_pick == 0) pd_pick = 1;
               target = TARGET_W'(($urandom_range(1) ? 20000 : 10000) / pd_pick
                                  + $urandom_range(2) - 1);
            end else begin
               target = TARGET_W'($urandom_range(T_MAX, T_MIN));
            end
            issue_request(target, 1'b0);
         end
      end

      // Let the last request finish and watch for stray strobes.
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("pll_divider_search verification clean");
      else
         $display("pll_divider_search verification failed");
      $finish;
   end

endmodule
